// ----- hdl/rdt_pkg.sv -----
// Shared types, constants and the wheel ratio function of the ramped differential torque block.
// No dependencies; every other file in hdl imports this package.
package rdt_pkg;

   // Fixed field widths
   localparam int unsigned LEVEL_BITS     = 16;
   localparam int unsigned TORQUE_BITS    = 16;
   localparam int unsigned CSR_DATA_BITS  = 8;
   localparam int unsigned CSR_INDEX_BITS = 1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TORQUE_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_STEP    = 1'b1;

   // Configuration reset values
   localparam logic [CSR_DATA_BITS-1:0] TORQUE_LIMIT_RESET = 8'd25;
   localparam logic [CSR_DATA_BITS-1:0] RAMP_STEP_RESET    = 8'd128;

   // Ratio curve constants
   localparam int unsigned     ANGLE_SPLIT = 2048;
   localparam longint unsigned LN2_Q30     = 64'd744261118;
   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned LIN_DEN     = 64'd100000;
   localparam longint unsigned LOG_OFF     = 64'd7590 * Q30_ONE;
   localparam longint unsigned LOG_DEN     = 64'd1000 * Q30_ONE;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic multiply;
      logic load;
   } rdt_cmd_type;

   // Base-2 logarithm in Q30 by normalizing to [1,2) and repeated squaring.
   function automatic longint unsigned log2_q30(input int unsigned a);
      int unsigned     t;
      int unsigned     e;
      longint unsigned m;
      longint unsigned frac;
      t    = a;
      e    = 0;
      frac = 0;
      for (int i = 0; i < 32; i++) begin
         if (t > 1) begin
            t = t >> 1;
            e = e + 1;
         end
      end
      m = longint'(a) << (30 - e);
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 30;
         if (m >= (Q30_ONE << 1)) begin
            m    = m >> 1;
            frac = frac | (64'd1 << (29 - i));
         end
      end
      return (longint'(e) << 30) | frac;
   endfunction

   // Wheel ratio in Q2.frac_bits for one angle; evaluated only at elaboration
   // to fill the ratio ROM.
   function automatic longint unsigned ratio_value(input int unsigned angle,
                                                   input int unsigned frac_bits);
      longint unsigned r;
      longint unsigned cap;
      longint unsigned num;
      longint unsigned ln;
      longint unsigned pos;
      cap = (64'd4 << frac_bits) - 64'd1;
      if (angle <= ANGLE_SPLIT) begin
         num = 64'd99972 - 64'd31 * longint'(angle);
         r   = ((num << frac_bits) + LIN_DEN / 2) / LIN_DEN;
      end else begin
         ln  = (log2_q30(angle) * LN2_Q30 + (64'd1 << 29)) >> 30;
         pos = 64'd1033 * ln;
         if (pos <= LOG_OFF) begin
            r = 64'd0;
         end else begin
            r = (((pos - LOG_OFF) << frac_bits) + LOG_DEN / 2) / LOG_DEN;
         end
      end
      return (r > cap) ? cap : r;
   endfunction

endpackage

// ----- hdl/rdt_channels.sv -----
// Valid/ready channel interfaces for the tick requests and the torque responses.
// Depends on rdt_pkg for the torque width.
interface rdt_req_if
   import rdt_pkg::*;
#(
   parameter int ANGLE_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic                  accelerate;
   logic [ANGLE_BITS-1:0] steer_pos;

   modport source (output valid, output accelerate, output steer_pos, input ready);
   modport sink   (input valid, input accelerate, input steer_pos, output ready);
endinterface

interface rdt_rsp_if
   import rdt_pkg::*;
#(
   parameter int ANGLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [TORQUE_BITS-1:0] torque_right_out;
   logic [TORQUE_BITS-1:0] torque_left_out;
   logic [ANGLE_BITS-1:0]  angle_echo;

   modport source (output valid, output torque_right_out, output torque_left_out,
                   output angle_echo, input ready);
   modport sink   (input valid, input torque_right_out, input torque_left_out,
                   input angle_echo, output ready);
endinterface

// ----- hdl/rdt_ctrl.sv -----
// Sequencer of the torque block: accept, ROM lookup, multiply, load of the output register.
// Depends on rdt_pkg for the command struct.
module rdt_ctrl
   import rdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rdt_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_LOOKUP   = 4'b0010,
      ST_MULTIPLY = 4'b0100,
      ST_LOAD     = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   // The output register can take a new beat when empty or being drained.
   assign out_free = !out_valid_ff || rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid flag: set on load, cleared when the beat is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   // A waiting result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !cmd.load)
      else $error("result overwritten while stalled");

   // An accepted beat always moves on to the ROM lookup.
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_LOOKUP))
      else $error("accepted beat did not start a lookup");

   // A load always presents a result on the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid)
      else $error("loaded result not presented");

   // A stalled result stays valid.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

// ----- hdl/rdt_datapath.sv -----
// Datapath of the torque block: configuration registers, ramp level, ratio ROM,
// shared multiplier and the output register. Depends on rdt_pkg.
module rdt_datapath
   import rdt_pkg::*;
#(
   parameter int ANGLE_BITS      = 12,
   parameter int RATIO_FRAC_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rdt_cmd_type               cmd,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      accelerate,
   input  logic [ANGLE_BITS-1:0]     steer_pos,
   output logic [TORQUE_BITS-1:0]    torque_right_out,
   output logic [TORQUE_BITS-1:0]    torque_left_out,
   output logic [ANGLE_BITS-1:0]     angle_echo
);

   localparam int DEPTH     = 1 << ANGLE_BITS;
   localparam int RATIO_W   = RATIO_FRAC_BITS + 2;
   localparam int PROD_W    = LEVEL_BITS + RATIO_W;
   localparam int SCALED_W  = PROD_W + 1 - RATIO_FRAC_BITS;
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (RATIO_FRAC_BITS - 1);
   localparam logic [SCALED_W-1:0] TORQUE_MAX = SCALED_W'((1 << TORQUE_BITS) - 1);

   logic [CSR_DATA_BITS-1:0] torque_limit_ff;
   logic [CSR_DATA_BITS-1:0] ramp_step_ff;
   logic [LEVEL_BITS-1:0]    level_ff, level_in;
   logic                     accel_ff;
   logic [ANGLE_BITS-1:0]    angle_ff;
   logic [RATIO_W-1:0]       ratio_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [TORQUE_BITS-1:0]   right_ff, right_in;
   logic [TORQUE_BITS-1:0]   left_ff, left_in;
   logic [ANGLE_BITS-1:0]    echo_ff;
   logic [LEVEL_BITS:0]      level_sum;
   logic [LEVEL_BITS-1:0]    level_cap;
   logic [PROD_W:0]          prod_round;
   logic [SCALED_W-1:0]      scaled;
   logic [TORQUE_BITS-1:0]   scaled_sat;
   logic                     linear_side;
   logic [RATIO_W-1:0]       rom_data [DEPTH];

   // Ratio ROM, one constant entry per angle.
   for (genvar g = 0; g < DEPTH; g++) begin : g_rom
      localparam logic [RATIO_W-1:0] ENTRY = RATIO_W'(ratio_value(g, RATIO_FRAC_BITS));
      assign rom_data[g] = ENTRY;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         torque_limit_ff <= TORQUE_LIMIT_RESET;
         ramp_step_ff    <= RAMP_STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TORQUE_LIMIT: torque_limit_ff <= csr_write_data;
            CSR_RAMP_STEP:    ramp_step_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Ramp update on each lookup: cleared when accelerate is clear, else saturating at the limit in whole units.
   always_comb begin
      level_sum = {1'b0, level_ff} + (LEVEL_BITS + 1)'(ramp_step_ff);
      level_cap = {torque_limit_ff, 8'h00};
      level_in  = level_ff;
      if (cmd.lookup) begin
         if (!accel_ff) begin
            level_in = '0;
         end else if (level_sum > {1'b0, level_cap}) begin
            level_in = level_cap;
         end else begin
            level_in = level_sum[LEVEL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   // Input capture, ROM read and product stage.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         accel_ff <= accelerate;
         angle_ff <= steer_pos;
      end
      if (cmd.lookup) begin
         ratio_ff <= rom_data[angle_ff];
      end
      if (cmd.multiply) begin
         prod_ff <= PROD_W'(level_ff) * PROD_W'(ratio_ff);
      end
   end

   // Rounding, saturation and wheel selection.
   always_comb begin
      prod_round  = {1'b0, prod_ff} + ROUND_HALF;
      scaled      = prod_round[PROD_W:RATIO_FRAC_BITS];
      scaled_sat  = (scaled > TORQUE_MAX) ? '1 : scaled[TORQUE_BITS-1:0];
      linear_side = (32'(angle_ff) <= ANGLE_SPLIT);
      right_in    = '0;
      left_in     = '0;
      if (accel_ff) begin
         if (linear_side) begin
            right_in = scaled_sat;
            left_in  = level_ff;
         end else begin
            right_in = level_ff;
            left_in  = scaled_sat;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         right_ff <= right_in;
         left_ff  <= left_in;
         echo_ff  <= angle_ff;
      end
   end

   assign torque_right_out = right_ff;
   assign torque_left_out  = left_ff;
   assign angle_echo       = echo_ff;

endmodule

// ----- hdl/ramped_differential_torque.sv -----
// Top level of the ramped differential torque block.
// Joins rdt_ctrl and rdt_datapath; depends on rdt_pkg and the rdt_channels interfaces.
//
// Use: each beat on req_ch is one control tick (accelerate bit and steering angle).
// Each tick gives exactly one beat on rsp_ch with the right and left torques in
// 1/256 units and the echoed angle. While accelerate is set, the ramp level rises
// by ramp_step per tick up to torque_limit whole units; the inner wheel gets the
// level scaled by a wheel ratio read from a ROM indexed by the angle. While
// accelerate is clear, the level and both torques are zero.
// Configuration: csr_write_enable, csr_index (0 torque_limit, 1 ramp_step) and
// csr_write_data; write only while no tick is in flight.
// Sequence: an accepted tick passes through the ROM read, multiply and load steps into the
// output register; the block takes a new tick only after the previous one has loaded.
// Reset: synchronous; clears the ramp level, restores torque_limit 25 and
// ramp_step 128, and empties the output register.
// Stall: a result waits in the output register while rsp_ch.ready is low; the
// block still accepts and works one further tick, which waits to load until the
// register is taken.
module ramped_differential_torque
   import rdt_pkg::*;
#(
   parameter int ANGLE_BITS      = 12,
   parameter int RATIO_FRAC_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   rdt_req_if.sink                   req_ch,
   rdt_rsp_if.source                 rsp_ch,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   rdt_cmd_type cmd;

   // Sequencer.
   rdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // Arithmetic and storage.
   rdt_datapath #(
      .ANGLE_BITS      (ANGLE_BITS),
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accelerate       (req_ch.accelerate),
      .steer_pos        (req_ch.steer_pos),
      .torque_right_out (rsp_ch.torque_right_out),
      .torque_left_out  (rsp_ch.torque_left_out),
      .angle_echo       (rsp_ch.angle_echo)
   );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for ramped_differential_torque: random valid/ready traffic,
// register changes between phases and an in-order torque predictor in this file.
// Depends on rdt_pkg and the rdt_req_if / rdt_rsp_if interfaces from hdl.
module tb_top
   import rdt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_W       = 12;
   localparam int FRAC_W        = 14;
   localparam int RATIO_W       = FRAC_W + 2;
   localparam int GAP_MAX       = 12;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT   = 500000;

   typedef struct packed {
      logic               accel;
      logic [ANGLE_W-1:0] angle;
   } tick_type;

   typedef struct packed {
      logic [TORQUE_BITS-1:0] right;
      logic [TORQUE_BITS-1:0] left;
      logic [ANGLE_W-1:0]     angle;
   } torque_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   rdt_req_if #(.ANGLE_BITS(ANGLE_W)) req_ch ();
   rdt_rsp_if #(.ANGLE_BITS(ANGLE_W)) rsp_ch ();

   ramped_differential_torque #(
      .ANGLE_BITS      (ANGLE_W),
      .RATIO_FRAC_BITS (FRAC_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Pending ticks, predicted torque beats and bookkeeping.
   tick_type    tick_q[$];
   torque_type  torque_q[$];
   int unsigned ticks_issued   = 0;
   int unsigned ticks_accepted = 0;
   int unsigned beats_checked  = 0;
   int unsigned reg_writes     = 0;
   int unsigned mismatches     = 0;
   int unsigned cycle_count    = 0;

   // Predictor state: ramp level and register copies.
   logic [LEVEL_BITS-1:0]    ramp_lvl  = '0;
   logic [CSR_DATA_BITS-1:0] limit_cfg = TORQUE_LIMIT_RESET;
   logic [CSR_DATA_BITS-1:0] step_cfg  = RAMP_STEP_RESET;

   // Handshake flags seen at the last rising edge.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Idle control for both sides.
   int unsigned req_gap    = 0;
   bit          gap_drawn  = 1'b0;
   bit          req_burst  = 1'b0;
   int unsigned rsp_stall  = 0;
   bit          rsp_burst  = 1'b0;

   always #4 clock = ~clock;

   // Base-2 logarithm in Q30: normalize to [1,2), then square repeatedly and
   // pick off one fraction bit each time the square reaches 2.
   function automatic longint unsigned log2_fixed(input int unsigned a);
      int unsigned     whole;
      longint unsigned mant;
      longint unsigned bits;
      whole = 0;
      while ((a >> (whole + 1)) != 0) whole++;
      mant = 64'(a) << (30 - whole);
      bits = 0;
      for (int k = 29; k >= 0; k--) begin
         mant = (mant * mant) >> 30;
         if (mant >= (64'd2 << 30)) begin
            mant    = mant >> 1;
            bits[k] = 1'b1;
         end
      end
      return (64'(whole) << 30) | bits;
   endfunction

   // Wheel ratio in Q2.14: straight line up to the split angle, log curve above.
   function automatic logic [RATIO_W-1:0] wheel_ratio_q14(input logic [ANGLE_W-1:0] angle);
      longint unsigned r;
      longint unsigned ln_q30;
      longint unsigned curve;
      longint unsigned ceiling;
      ceiling = (64'd4 << FRAC_W) - 64'd1;
      if (angle <= ANGLE_SPLIT) begin
         r = (((64'd99972 - 64'd31 * 64'(angle)) << FRAC_W) + 64'd50000) / 64'd100000;
      end else begin
         ln_q30 = (log2_fixed(angle) * LN2_Q30 + (64'd1 << 29)) >> 30;
         curve  = 64'd1033 * ln_q30;
         if (curve <= LOG_OFF) begin
            r = 0;
         end else begin
            r = (((curve - LOG_OFF) << FRAC_W) + LOG_DEN / 2) / LOG_DEN;
         end
      end
      if (r > ceiling) r = ceiling;
      return r[RATIO_W-1:0];
   endfunction

   // Advance the ramp by one tick and work out the torques it produces.
   function automatic torque_type next_torques(input tick_type t);
      torque_type             o;
      logic [LEVEL_BITS:0]    sum;
      logic [LEVEL_BITS:0]    ceiling;
      logic [RATIO_W-1:0]     ratio;
      longint unsigned        prod;
      logic [TORQUE_BITS-1:0] scaled;
      o.angle = t.angle;
      o.right = '0;
      o.left  = '0;
      if (!t.accel) begin
         ramp_lvl = '0;
      end else begin
         sum      = {1'b0, ramp_lvl} + (LEVEL_BITS + 1)'(step_cfg);
         ceiling  = {1'b0, limit_cfg, 8'h00};
         ramp_lvl = (sum > ceiling) ? ceiling[LEVEL_BITS-1:0] : sum[LEVEL_BITS-1:0];
         ratio    = wheel_ratio_q14(t.angle);
         prod     = (64'(ramp_lvl) * 64'(ratio) + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
         scaled   = (prod > 64'd65535) ? 16'hFFFF : prod[TORQUE_BITS-1:0];
         // The inner wheel gets the scaled level, the outer one the plain level.
         if (t.angle <= ANGLE_SPLIT) begin
            o.right = scaled;
            o.left  = ramp_lvl;
         end else begin
            o.left  = scaled;
            o.right = ramp_lvl;
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      $display("MISMATCH beat %0d %s: got %0d, expected %0d", beats_checked, what, got, want);
   endtask

   task automatic queue_tick(input logic accel, input logic [ANGLE_W-1:0] angle);
      tick_type t;
      t.accel = accel;
      t.angle = angle;
      tick_q.push_back(t);
      ticks_issued++;
   endtask

   // Wait until every tick is taken and every beat has come back, then let the
   // pipeline go quiet.
   task automatic settle();
      while (ticks_accepted != ticks_issued || torque_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      reg_writes++;
   endtask

   // Request driver: holds a beat until it is taken, then waits a drawn gap.
   always @(negedge clock) begin : req_driver
      tick_type nxt;
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.accelerate <= 1'b0;
         req_ch.steer_pos  <= '0;
         gap_drawn = 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (!gap_drawn) begin
            if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
            req_gap   = req_burst ? 0 : $urandom_range(0, GAP_MAX);
            gap_drawn = 1'b1;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (tick_q.size() != 0) begin
            nxt = tick_q.pop_front();
            req_ch.accelerate <= nxt.accel;
            req_ch.steer_pos  <= nxt.angle;
            req_ch.valid      <= 1'b1;
            gap_drawn = 1'b0;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response ready: after each taken beat, stall for a drawn number of cycles.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Monitor: tracks register writes, predicts each taken tick and checks each
   // taken result beat against the oldest prediction.
   always @(posedge clock) begin : monitor
      torque_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         ramp_lvl  = '0;
         limit_cfg = TORQUE_LIMIT_RESET;
         step_cfg  = RAMP_STEP_RESET;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TORQUE_LIMIT: limit_cfg = csr_write_data;
               CSR_RAMP_STEP:    step_cfg  = csr_write_data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            torque_q.push_back(next_torques({req_ch.accelerate, req_ch.steer_pos}));
            ticks_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (torque_q.size() == 0) begin
               report_mismatch("unexpected beat, right torque", rsp_ch.torque_right_out, 0);
            end else begin
               want = torque_q.pop_front();
               if (rsp_ch.torque_right_out !== want.right)
                  report_mismatch("torque_right_out", rsp_ch.torque_right_out, want.right);
               if (rsp_ch.torque_left_out !== want.left)
                  report_mismatch("torque_left_out", rsp_ch.torque_left_out, want.left);
               if (rsp_ch.angle_echo !== want.angle)
                  report_mismatch("angle_echo", rsp_ch.angle_echo, want.angle);
            end
            beats_checked++;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d beats outstanding.",
                  cycle_count, torque_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus: directed corners first, then random phases under changing limits.
   initial begin
      int unsigned limit_pick;
      int unsigned step_pick;
      int unsigned accel_pct;
      int unsigned count;
      int unsigned sel;
      logic [ANGLE_W-1:0] angle;

      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_TORQUE_LIMIT;
      csr_write_data     = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: angle extremes, both sides of the split, both operations.
      queue_tick(1'b1, 12'd0);
      queue_tick(1'b1, 12'd1);
      queue_tick(1'b1, 12'd2047);
      queue_tick(1'b1, 12'd2048);
      queue_tick(1'b1, 12'd2049);
      queue_tick(1'b1, 12'd2050);
      queue_tick(1'b1, 12'h555);
      queue_tick(1'b1, 12'hAAA);
      queue_tick(1'b1, 12'd4094);
      queue_tick(1'b1, 12'd4095);
      queue_tick(1'b0, 12'd4095);
      queue_tick(1'b1, 12'd3000);
      settle();

      // Ramp high, then lower the limit so the next accelerating tick clamps down.
      write_reg(CSR_TORQUE_LIMIT, 8'd255);
      write_reg(CSR_RAMP_STEP, 8'd255);
      for (int i = 0; i < 6; i++) queue_tick(1'b1, 12'(i * 700));
      settle();
      write_reg(CSR_TORQUE_LIMIT, 8'd2);
      queue_tick(1'b1, 12'd100);
      queue_tick(1'b1, 12'd3500);
      settle();

      // Zero limit holds the level at zero; zero step never lets it rise.
      write_reg(CSR_TORQUE_LIMIT, 8'd0);
      write_reg(CSR_RAMP_STEP, 8'd200);
      queue_tick(1'b1, 12'd10);
      queue_tick(1'b1, 12'd4000);
      settle();
      write_reg(CSR_TORQUE_LIMIT, 8'd255);
      write_reg(CSR_RAMP_STEP, 8'd0);
      queue_tick(1'b0, 12'd0);
      queue_tick(1'b1, 12'd2048);
      queue_tick(1'b1, 12'd2049);
      settle();

      // Random phases; the first one ramps all the way to full saturation.
      for (int p = 0; p < 10; p++) begin
         if (p == 0) begin
            limit_pick = 255;
            step_pick  = 255;
            accel_pct  = 100;
            count      = 280;
         end else begin
            case ($urandom_range(0, 4))
               0:       limit_pick = 0;
               1:       limit_pick = 255;
               2, 3:    limit_pick = $urandom_range(1, 20);
               default: limit_pick = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 4))
               0:       step_pick = 0;
               1:       step_pick = 255;
               2:       step_pick = 1;
               default: step_pick = $urandom_range(0, 255);
            endcase
            accel_pct = $urandom_range(85, 100);
            count     = 130;
         end
         write_reg(CSR_TORQUE_LIMIT, 8'(limit_pick));
         write_reg(CSR_RAMP_STEP, 8'(step_pick));
         for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 7);
            if (sel < 2) angle = 12'($urandom_range(2040, 2056));
            else if (sel == 2) angle = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            else angle = 12'($urandom_range(0, 4095));
            queue_tick($urandom_range(0, 99) < accel_pct, angle);
         end
         settle();
      end

      $display("Ran %0d ticks, %0d result beats checked, over %0d register writes.",
               ticks_issued, beats_checked, reg_writes);
      $display("Covered angle corners, ramp saturation, limit clamping and zero settings.");
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches found.", mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
